// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the scalar instruction decoder.
// Depends on nothing; synthesis builds define SYNTHESIS to drop the checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define S16D_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Assertion failed.");

// Next-cycle implication, disabled while reset is asserted.
`define S16D_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Assertion failed.");

`else

`define S16D_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define S16D_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/s16d_pkg.sv =====
// Types and constants of the scalar 16-bit instruction decoder.
// Depends on nothing; used by the decode logic and the top level.
`timescale 1ns / 1ps

package s16d_pkg;

    localparam logic [3:0] CLS_NOARG      = 4'd0;
    localparam logic [3:0] CLS_SWI_REG    = 4'd1;
    localparam logic [3:0] CLS_BRANCH_REG = 4'd2;
    localparam logic [3:0] CLS_SWITCH     = 4'd3;
    localparam logic [3:0] CLS_VERSION    = 4'd4;
    localparam logic [3:0] CLS_SWI_IMM    = 4'd5;
    localparam logic [3:0] CLS_COND_BR    = 4'd6;
    localparam logic [3:0] CLS_ADD_SP     = 4'd7;
    localparam logic [3:0] CLS_LDM_STM    = 4'd8;
    localparam logic [3:0] CLS_LD_SP      = 4'd9;
    localparam logic [3:0] CLS_LDST_REG   = 4'd10;
    localparam logic [3:0] CLS_ALU_RR     = 4'd11;
    localparam logic [3:0] CLS_ALU_RI     = 4'd12;

    localparam logic [7:0] NOARG_LAST     = 8'd10;
    localparam logic [4:0] VERSION_REG    = 5'd31;

    localparam logic [4:0] ALU_OP_SHL1    = 5'd19;
    localparam logic [4:0] ALU_OP_SHLN_LO = 5'd21;
    localparam logic [4:0] ALU_OP_SHLN_HI = 5'd23;
    localparam logic [3:0] ALU_RI_SHL_GRP = 4'd3;
    localparam logic [2:0] ALU_RI_SHIFT   = 3'd3;

    typedef struct packed {
        logic [3:0] insn_class;
        logic [4:0] op_index;
        logic [4:0] reg_d;
        logic [4:0] reg_s;
        logic [6:0] immediate;
        logic [3:0] cond_code;
        logic [1:0] access_width;
        logic [2:0] shift_amount;
        logic       store_flag;
        logic       variant_flag;
    } s16d_dec_t;

    function automatic logic [4:0] base_reg(input logic [1:0] sel);
        logic [4:0] r;
        case (sel)
            2'd0:    r = 5'd0;
            2'd1:    r = 5'd6;
            2'd2:    r = 5'd16;
            default: r = 5'd24;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/s16d_in_if.sv =====
// Input channel of the decoder: one raw instruction half-word per transfer.
// Depends on nothing.
`timescale 1ns / 1ps

interface s16d_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] instr_half;

    modport source (output valid, output instr_half, input ready);
    modport sink (input valid, input instr_half, output ready);
endinterface

// ===== rtl/s16d_out_if.sv =====
// Output channel of the decoder: one decoded instruction per transfer.
// Depends on nothing.
`timescale 1ns / 1ps

interface s16d_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] insn_class;
    logic [4:0] op_index;
    logic [4:0] reg_d;
    logic [4:0] reg_s;
    logic [6:0] immediate;
    logic [3:0] cond_code;
    logic [1:0] access_width;
    logic [2:0] shift_amount;
    logic       store_flag;
    logic       variant_flag;

    modport source (
        output valid, output insn_class, output op_index, output reg_d, output reg_s,
        output immediate, output cond_code, output access_width, output shift_amount,
        output store_flag, output variant_flag, input ready
    );
    modport sink (
        input valid, input insn_class, input op_index, input reg_d, input reg_s,
        input immediate, input cond_code, input access_width, input shift_amount,
        input store_flag, input variant_flag, output ready
    );
endinterface

// ===== rtl/s16d_decode.sv =====
// Combinational decode of one 16-bit scalar instruction half-word.
// Depends on s16d_pkg for the result type, class codes and base register table.
`timescale 1ns / 1ps

module s16d_decode (
    input  logic [15:0]          instr,
    output s16d_pkg::s16d_dec_t  dec
);

    logic [4:0] alu_rr_op;
    logic [3:0] alu_ri_grp;

    assign alu_rr_op  = instr[12:8];
    assign alu_ri_grp = instr[12:9];

    always_comb
    begin
        dec = '0;
        if (instr[15:8] == 8'd0)
        begin
            if (instr[7:0] <= s16d_pkg::NOARG_LAST)
            begin
                dec.insn_class = s16d_pkg::CLS_NOARG;
                dec.op_index   = instr[4:0];
            end
            else if (instr[5] && !instr[6])
            begin
                dec.insn_class = s16d_pkg::CLS_SWI_REG;
                dec.reg_d      = instr[4:0];
            end
            else if (instr[6])
            begin
                dec.insn_class   = s16d_pkg::CLS_BRANCH_REG;
                dec.reg_d        = instr[4:0];
                dec.variant_flag = instr[5];
            end
            else if (instr[7])
            begin
                dec.insn_class   = s16d_pkg::CLS_SWITCH;
                dec.reg_d        = {1'b0, instr[3:0]};
                dec.variant_flag = instr[5];
            end
            else if (instr[4])
            begin
                dec.insn_class = s16d_pkg::CLS_VERSION;
                dec.reg_d      = s16d_pkg::VERSION_REG;
            end
            else
            begin
                dec.insn_class = s16d_pkg::CLS_SWI_IMM;
                dec.immediate  = {1'b0, instr[5:0]};
            end
        end
        else if (instr[12] && !instr[14])
        begin
            if (instr[11])
            begin
                dec.insn_class = s16d_pkg::CLS_COND_BR;
                dec.cond_code  = instr[10:7];
                dec.immediate  = instr[6:0];
            end
            else
            begin
                dec.insn_class = s16d_pkg::CLS_ADD_SP;
                dec.reg_d      = instr[4:0];
                dec.immediate  = {1'b0, instr[10:5]};
            end
        end
        else if (!instr[14])
        begin
            if (instr[9] && !(instr[10] && instr[11]))
            begin
                dec.insn_class   = s16d_pkg::CLS_LDM_STM;
                dec.reg_s        = s16d_pkg::base_reg(instr[6:5]);
                dec.reg_d        = instr[4:0];
                dec.store_flag   = instr[7];
                dec.variant_flag = instr[8];
            end
            else if (instr[10] && !instr[11])
            begin
                dec.insn_class = s16d_pkg::CLS_LD_SP;
                dec.reg_d      = {1'b0, instr[3:0]};
                dec.immediate  = {2'b00, instr[8:4]};
                dec.store_flag = instr[9];
            end
            else
            begin
                dec.insn_class   = s16d_pkg::CLS_LDST_REG;
                dec.store_flag   = instr[8];
                dec.access_width = instr[10:9];
                dec.reg_s        = {1'b0, instr[7:4]};
                dec.reg_d        = {1'b0, instr[3:0]};
            end
        end
        else if (instr[13])
        begin
            dec.insn_class = s16d_pkg::CLS_ALU_RI;
            dec.op_index   = {alu_ri_grp, 1'b0};
            dec.reg_d      = {1'b0, instr[3:0]};
            dec.immediate  = {2'b00, instr[8:4]};
            if (alu_ri_grp == s16d_pkg::ALU_RI_SHL_GRP)
            begin
                dec.shift_amount = s16d_pkg::ALU_RI_SHIFT;
            end
        end
        else
        begin
            dec.insn_class = s16d_pkg::CLS_ALU_RR;
            dec.op_index   = alu_rr_op;
            dec.reg_d      = {1'b0, instr[3:0]};
            dec.reg_s      = {1'b0, instr[7:4]};
            if (alu_rr_op == s16d_pkg::ALU_OP_SHL1)
            begin
                dec.shift_amount = 3'd1;
            end
            else if (alu_rr_op >= s16d_pkg::ALU_OP_SHLN_LO
                     && alu_rr_op <= s16d_pkg::ALU_OP_SHLN_HI)
            begin
                dec.shift_amount = 3'(alu_rr_op - s16d_pkg::ALU_OP_SHL1);
            end
        end
    end

endmodule

// ===== rtl/scalar16_instruction_decoder.sv =====
// Top level of the scalar 16-bit instruction decoder: input register, decode, result register.
// Depends on s16d_pkg, s16d_in_if, s16d_out_if, s16d_decode and assert_macros.svh.
//
//  Channel   Role   Payload
//  insn_in   sink   instr_half (16 bits)
//  dec_out   source insn_class, op_index, reg_d, reg_s, immediate, cond_code,
//                   access_width, shift_amount, store_flag, variant_flag
//
// A half-word is accepted every cycle while insn_in.ready is high; it is held in the input
// register, and its decoded result is held in the result register that drives the output.
// The decode logic between the two registers sets the clock period.
// Reset empties both registers; no payload is cleared.
// A stall on the output holds the result register, and the input register keeps
// taking one more transfer before the input side stalls too.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scalar16_instruction_decoder (
    input  logic              clk,
    input  logic              rst_n,
    s16d_in_if.sink           insn_in,
    s16d_out_if.source        dec_out
);

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic [15:0]          s1_instr_reg;
    logic                 s2_valid_reg;
    logic                 s2_valid_next;
    s16d_pkg::s16d_dec_t  s2_dec_reg;
    s16d_pkg::s16d_dec_t  dec;
    logic                 in_xfer;
    logic                 s1_adv;

    assign s1_adv        = !s2_valid_reg || dec_out.ready;
    assign insn_in.ready = !s1_valid_reg || s1_adv;
    assign in_xfer       = insn_in.valid && insn_in.ready;

    s16d_decode u_decode (
        .instr (s1_instr_reg),
        .dec   (dec)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        s2_valid_next = s1_adv ? s1_valid_reg : s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_instr_reg <= insn_in.instr_half;
        end
        if (s1_adv && s1_valid_reg)
        begin
            s2_dec_reg <= dec;
        end
    end

    assign dec_out.valid        = s2_valid_reg;
    assign dec_out.insn_class   = s2_dec_reg.insn_class;
    assign dec_out.op_index     = s2_dec_reg.op_index;
    assign dec_out.reg_d        = s2_dec_reg.reg_d;
    assign dec_out.reg_s        = s2_dec_reg.reg_s;
    assign dec_out.immediate    = s2_dec_reg.immediate;
    assign dec_out.cond_code    = s2_dec_reg.cond_code;
    assign dec_out.access_width = s2_dec_reg.access_width;
    assign dec_out.shift_amount = s2_dec_reg.shift_amount;
    assign dec_out.store_flag   = s2_dec_reg.store_flag;
    assign dec_out.variant_flag = s2_dec_reg.variant_flag;

    `S16D_ASSERT_NXT(a_in_lands, clk, rst_n, in_xfer, s1_valid_reg)
    `S16D_ASSERT_NXT(a_s1_holds, clk, rst_n,
        s1_valid_reg && !s1_adv,
        s1_valid_reg && $stable(s1_instr_reg))
    `S16D_ASSERT_IMP(a_class_range, clk, rst_n,
        s2_valid_reg,
        s2_dec_reg.insn_class <= s16d_pkg::CLS_ALU_RI)
    `S16D_ASSERT_IMP(a_shift_alu_only, clk, rst_n,
        s2_valid_reg && s2_dec_reg.insn_class != s16d_pkg::CLS_ALU_RR
            && s2_dec_reg.insn_class != s16d_pkg::CLS_ALU_RI,
        s2_dec_reg.shift_amount == 3'd0)

endmodule
